/* rtl/gpio_pei_pkg.sv */
// Package: constants, types and edge-config decode for the GPIO edge interrupt port.
`default_nettype none

package gpio_pei_pkg;

    localparam int PIN_COUNT = 8;
    localparam logic [7:0] PIN_MASK = 8'((1 << PIN_COUNT) - 1);

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PIN   = 2'd2;

    localparam logic [3:0] REG_DATA    = 4'd0;
    localparam logic [3:0] REG_DIR     = 4'd1;
    localparam logic [3:0] REG_CON_LO  = 4'd2;
    localparam logic [3:0] REG_CON_HI  = 4'd3;
    localparam logic [3:0] REG_MA_LO   = 4'd4;
    localparam logic [3:0] REG_MA_HI   = 4'd5;
    localparam logic [3:0] REG_MB_LO   = 4'd6;
    localparam logic [3:0] REG_MB_HI   = 4'd7;
    localparam logic [3:0] REG_EDGE0   = 4'd8;
    localparam logic [3:0] REG_EDGE1   = 4'd9;
    localparam logic [3:0] REG_EDGE2   = 4'd10;
    localparam logic [3:0] REG_EDGE3   = 4'd11;
    localparam logic [3:0] REG_SET     = 4'd12;
    localparam logic [3:0] REG_STATUS  = 4'd13;
    localparam logic [3:0] REG_CLEAR   = 4'd14;
    localparam logic [3:0] REG_UPDATE  = 4'd15;

    localparam logic [2:0] EDGE_FALL = 3'd0;
    localparam logic [2:0] EDGE_RISE = 3'd1;
    localparam logic [2:0] EDGE_BOTH = 3'd4;

    typedef struct packed {
        logic [7:0] rise;
        logic [7:0] fall;
    } t_edge_masks;

    function automatic t_edge_masks decode_edges(input logic [31:0] cfg);
        t_edge_masks m;
        logic [2:0]  kind;
        m = '0;
        for (int n = 0; n < PIN_COUNT; n++) begin
            kind = cfg[n*4 +: 3];
            case (kind)
                EDGE_FALL: m.fall[n] = 1'b1;
                EDGE_RISE: m.rise[n] = 1'b1;
                EDGE_BOTH: begin
                    m.rise[n] = 1'b1;
                    m.fall[n] = 1'b1;
                end
                default: ;
            endcase
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/gpio_port_edge_interrupt_core.sv */
// Results reach the outputs through the input register and then the result register.
// Throughput: one transaction per cycle; input register and result register
// both advance unless the result is held by stall.
// Reset: synchronous, active low; clears all port registers and both valids.
// Top level: GPIO port with edge interrupt detection.
`default_nettype none

module gpio_port_edge_interrupt_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [3:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic [7:0] i_pin_input,
    input  wire logic [7:0] i_pin_present,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_data,
    output logic [7:0]      o_pin_output,
    output logic [7:0]      o_port_level,
    output logic            o_edge_irq,
    output logic [7:0]      o_edge_pins,
    output logic [7:0]      o_status_flags
);

    logic        r_in_valid;
    logic [1:0]  r_opcode;
    logic [3:0]  r_reg_index;
    logic [7:0]  r_write_data;
    logic [7:0]  r_pin_input;
    logic [7:0]  r_pin_present;

    logic [7:0]  r_out_data,    n_out_data;
    logic [7:0]  r_direction,   n_direction;
    logic [15:0] r_control,     n_control;
    logic [15:0] r_mode_a,      n_mode_a;
    logic [15:0] r_mode_b,      n_mode_b;
    logic [31:0] r_edge_config, n_edge_config;
    logic [7:0]  r_rise_mask,   n_rise_mask;
    logic [7:0]  r_fall_mask,   n_fall_mask;
    logic [7:0]  r_irq_status,  n_irq_status;
    logic [7:0]  r_ext_level,   n_ext_level;
    logic [7:0]  r_ext_present, n_ext_present;
    logic [7:0]  r_prev_input,  n_prev_input;
    logic [7:0]  r_level_now,   n_level_now;

    logic        r_out_valid;
    logic [7:0]  r_read_data,   n_read_data;
    logic [7:0]  r_edge_pins,   n_edge_pins;

    gpio_pei_pkg::t_edge_masks masks;
    logic        out_busy;
    logic        fire;
    logic        upd;
    logic        cfg_wr;
    logic [7:0]  held;
    logic [7:0]  cur;

    assign out_busy   = r_out_valid && i_out_stall;
    assign o_in_stall = r_in_valid && out_busy;
    assign fire       = r_in_valid && !out_busy;

    always_comb begin
        n_out_data    = r_out_data;
        n_direction   = r_direction;
        n_control     = r_control;
        n_mode_a      = r_mode_a;
        n_mode_b      = r_mode_b;
        n_edge_config = r_edge_config;
        n_rise_mask   = r_rise_mask;
        n_fall_mask   = r_fall_mask;
        n_irq_status  = r_irq_status;
        n_ext_level   = r_ext_level;
        n_ext_present = r_ext_present;
        n_prev_input  = r_prev_input;
        n_level_now   = r_level_now;
        n_read_data   = 8'd0;
        n_edge_pins   = 8'd0;
        upd           = 1'b0;
        cfg_wr        = 1'b0;

        case (r_opcode)
            gpio_pei_pkg::OP_READ: begin
                case (r_reg_index)
                    gpio_pei_pkg::REG_DATA:   n_read_data = r_level_now;
                    gpio_pei_pkg::REG_DIR:    n_read_data = r_direction;
                    gpio_pei_pkg::REG_CON_LO: n_read_data = r_control[7:0];
                    gpio_pei_pkg::REG_CON_HI: n_read_data = r_control[15:8];
                    gpio_pei_pkg::REG_MA_LO:  n_read_data = r_mode_a[7:0];
                    gpio_pei_pkg::REG_MA_HI:  n_read_data = r_mode_a[15:8];
                    gpio_pei_pkg::REG_MB_LO:  n_read_data = r_mode_b[7:0];
                    gpio_pei_pkg::REG_MB_HI:  n_read_data = r_mode_b[15:8];
                    gpio_pei_pkg::REG_EDGE0:  n_read_data = r_edge_config[7:0];
                    gpio_pei_pkg::REG_EDGE1:  n_read_data = r_edge_config[15:8];
                    gpio_pei_pkg::REG_EDGE2:  n_read_data = r_edge_config[23:16];
                    gpio_pei_pkg::REG_EDGE3:  n_read_data = r_edge_config[31:24];
                    gpio_pei_pkg::REG_STATUS: n_read_data = r_irq_status;
                    default:                  n_read_data = 8'd0;
                endcase
            end
            gpio_pei_pkg::OP_WRITE: begin
                case (r_reg_index)
                    gpio_pei_pkg::REG_DATA: begin
                        n_out_data = r_write_data;
                        upd        = 1'b1;
                    end
                    gpio_pei_pkg::REG_DIR: begin
                        n_direction = r_write_data;
                        upd         = 1'b1;
                    end
                    gpio_pei_pkg::REG_CON_LO: n_control[7:0]      = r_write_data;
                    gpio_pei_pkg::REG_CON_HI: n_control[15:8]     = r_write_data;
                    gpio_pei_pkg::REG_MA_LO:  n_mode_a[7:0]       = r_write_data;
                    gpio_pei_pkg::REG_MA_HI:  n_mode_a[15:8]      = r_write_data;
                    gpio_pei_pkg::REG_MB_LO:  n_mode_b[7:0]       = r_write_data;
                    gpio_pei_pkg::REG_MB_HI:  n_mode_b[15:8]      = r_write_data;
                    gpio_pei_pkg::REG_EDGE0: begin
                        n_edge_config[7:0] = r_write_data;
                        cfg_wr             = 1'b1;
                    end
                    gpio_pei_pkg::REG_EDGE1: begin
                        n_edge_config[15:8] = r_write_data;
                        cfg_wr              = 1'b1;
                    end
                    gpio_pei_pkg::REG_EDGE2: begin
                        n_edge_config[23:16] = r_write_data;
                        cfg_wr               = 1'b1;
                    end
                    gpio_pei_pkg::REG_EDGE3: begin
                        n_edge_config[31:24] = r_write_data;
                        cfg_wr               = 1'b1;
                    end
                    gpio_pei_pkg::REG_SET: begin
                        n_irq_status = r_irq_status | r_write_data;
                        upd          = 1'b1;
                    end
                    gpio_pei_pkg::REG_CLEAR: begin
                        n_irq_status = r_irq_status & ~r_write_data;
                        upd          = 1'b1;
                    end
                    gpio_pei_pkg::REG_UPDATE: upd = r_write_data[0];
                    default: ;
                endcase
            end
            gpio_pei_pkg::OP_PIN: begin
                n_ext_level   = r_pin_input;
                n_ext_present = r_pin_present;
                upd           = 1'b1;
            end
            default: ;
        endcase

        // masks stay clear until the first edge-config write
        masks = gpio_pei_pkg::decode_edges(n_edge_config);
        if (cfg_wr) begin
            n_rise_mask = masks.rise;
            n_fall_mask = masks.fall;
        end

        held = (n_ext_level & n_ext_present)
             | (n_control[15:8] & ~n_control[7:0] & ~n_ext_present);
        cur  = held & n_direction & gpio_pei_pkg::PIN_MASK;
        if (upd) begin
            n_level_now  = ((n_out_data & ~n_direction) | (held & n_direction))
                         & gpio_pei_pkg::PIN_MASK;
            n_edge_pins  = ((cur & ~r_prev_input & r_rise_mask)
                         | (r_prev_input & ~cur & r_fall_mask)) & gpio_pei_pkg::PIN_MASK;
            n_prev_input = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_opcode      <= i_opcode;
            r_reg_index   <= i_reg_index;
            r_write_data  <= i_write_data;
            r_pin_input   <= i_pin_input;
            r_pin_present <= i_pin_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_data    <= '0;
            r_direction   <= '0;
            r_control     <= '0;
            r_mode_a      <= '0;
            r_mode_b      <= '0;
            r_edge_config <= '0;
            r_rise_mask   <= '0;
            r_fall_mask   <= '0;
            r_irq_status  <= '0;
            r_ext_level   <= '0;
            r_ext_present <= '0;
            r_prev_input  <= '0;
            r_level_now   <= '0;
            r_out_valid   <= 1'b0;
            r_read_data   <= '0;
            r_edge_pins   <= '0;
        end else begin
            if (fire) begin
                r_out_data    <= n_out_data;
                r_direction   <= n_direction;
                r_control     <= n_control;
                r_mode_a      <= n_mode_a;
                r_mode_b      <= n_mode_b;
                r_edge_config <= n_edge_config;
                r_rise_mask   <= n_rise_mask;
                r_fall_mask   <= n_fall_mask;
                r_irq_status  <= n_irq_status;
                r_ext_level   <= n_ext_level;
                r_ext_present <= n_ext_present;
                r_prev_input  <= n_prev_input;
                r_level_now   <= n_level_now;
                r_read_data   <= n_read_data;
                r_edge_pins   <= n_edge_pins;
            end
            if (!out_busy) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_pin_output   = r_out_data & ~r_direction & gpio_pei_pkg::PIN_MASK;
    assign o_port_level   = r_level_now;
    assign o_edge_irq     = (r_edge_pins != 8'd0);
    assign o_edge_pins    = r_edge_pins;
    assign o_status_flags = r_irq_status;

`ifndef SYNTHESIS
    a_level_matches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((o_port_level & ~r_direction & gpio_pei_pkg::PIN_MASK)
                         == o_pin_output))
        else $error("port level disagrees with driven output pins");

    a_read_no_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_opcode == gpio_pei_pkg::OP_READ) |=> (o_edge_pins == 8'd0))
        else $error("edge reported on a bus read");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_read_data)
                                          && $stable(r_edge_pins)))
        else $error("held result changed");

    a_no_update_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_busy) |=> (r_in_valid && $stable(r_irq_status)
                                      && $stable(r_prev_input)))
        else $error("state advanced while result was held");
`endif

endmodule

`default_nettype wire
